// ===== rtl/core/tick_task_scheduler_top_defines.svh =====
// Assertion macros for the tick task scheduler; empty when synthesising.
`ifndef TICK_TASK_SCHEDULER_TOP_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset
`define TTS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Consequence that must hold in the cycle after the trigger
`define TTS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define TTS_ASSERT(lbl, expr, msg)
`define TTS_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

// ===== rtl/core/tts_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package tts_pkg;

    localparam int SLOT_W        = 6;
    localparam int ID_W          = 8;
    localparam int TIME_W        = 16;
    localparam int KIND_W        = 2;
    localparam int RES_W         = 2;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 16;
    localparam int MAX_TASKS_DEF = 8;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

    // Result kinds
    localparam logic [RES_W-1:0] RES_ADDED = 2'd0;
    localparam logic [RES_W-1:0] RES_FULL  = 2'd1;
    localparam logic [RES_W-1:0] RES_RUN   = 2'd2;
    localparam logic [RES_W-1:0] RES_IDLE  = 2'd3;

    // One slot entry held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
    } t_slot;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;       // capture input word, rewind scan
        logic rd;        // read slot memory at scan pointer
        logic tick_upd;  // count down / reload the current slot
        logic add_wr;    // fill the current slot with the new task
        logic take;      // dispatch current slot, push held result out
        logic adv;       // step the scan pointer
        logic fin;       // send the closing result of the word
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              slot_valid;
        logic              slot_pend;
        logic              ptr_last;
        logic              hold_valid;
        logic              out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/tts_dp.sv =====
// Datapath: slot table, scan pointer, held result and output register.
module tts_dp #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tts_pkg::t_dp_cmd            i_cmd,
    output tts_pkg::t_dp_sts            o_sts,
    input  logic [tts_pkg::KIND_W-1:0]  i_kind,
    input  logic [tts_pkg::ID_W-1:0]    i_ident,
    input  logic [tts_pkg::TIME_W-1:0]  i_sdelay,
    input  logic [tts_pkg::TIME_W-1:0]  i_period,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [tts_pkg::RES_W-1:0]   o_out_kind,
    output logic [tts_pkg::SLOT_W-1:0]  o_out_slot,
    output logic [tts_pkg::ID_W-1:0]    o_out_ident,
    output logic                        o_out_last
);

    // Captured input word
    logic [tts_pkg::KIND_W-1:0] r_kind;
    logic [tts_pkg::ID_W-1:0]   r_ident;
    logic [tts_pkg::TIME_W-1:0] r_sdelay;
    logic [tts_pkg::TIME_W-1:0] r_period;

    // Scan pointer and slot state
    logic [IDX_W-1:0]     r_ptr;
    logic [MAX_TASKS-1:0] r_valid;
    logic [MAX_TASKS-1:0] r_pend;
    tts_pkg::t_slot       r_mem [MAX_TASKS];
    tts_pkg::t_slot       r_rd;
    tts_pkg::t_slot       n_entry;
    logic                 n_mem_we;

    // Result held back until the next ready slot or the end of the scan
    logic                       r_hold_valid;
    logic [IDX_W-1:0]           r_hold_idx;
    logic [tts_pkg::ID_W-1:0]   r_hold_ident;

    // Output register
    logic                         r_out_valid;
    logic [tts_pkg::RES_W-1:0]    r_out_kind;
    logic [tts_pkg::SLOT_W-1:0]   r_out_slot;
    logic [tts_pkg::ID_W-1:0]     r_out_ident;
    logic                         r_out_last;

    logic out_free;
    logic rd_zero;

    assign out_free = !r_out_valid || i_out_ready;
    assign rd_zero  = (r_rd.delay == '0);

    // Status to the controller
    assign o_sts.kind       = r_kind;
    assign o_sts.slot_valid = r_valid[r_ptr];
    assign o_sts.slot_pend  = r_pend[r_ptr];
    assign o_sts.ptr_last   = (r_ptr == IDX_W'(MAX_TASKS - 1));
    assign o_sts.hold_valid = r_hold_valid;
    assign o_sts.out_free   = out_free;

    // Next slot entry: new task on add, countdown or reload on tick
    always_comb begin
        n_mem_we = i_cmd.add_wr || i_cmd.tick_upd;
        if (i_cmd.add_wr) begin
            n_entry.ident  = r_ident;
            n_entry.delay  = r_sdelay;
            n_entry.period = r_period;
        end else begin
            n_entry.ident  = r_rd.ident;
            n_entry.delay  = rd_zero ? r_rd.period : r_rd.delay - 1'b1;
            n_entry.period = r_rd.period;
        end
    end

    // Slot memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_ptr];
        end
        if (n_mem_we) begin
            r_mem[r_ptr] <= n_entry;
        end
    end

    // Input capture and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind   <= i_kind;
            r_ident  <= i_ident;
            r_sdelay <= i_sdelay;
            r_period <= i_period;
            r_ptr    <= '0;
        end else if (i_cmd.adv) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    // Valid and run flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pend  <= '0;
        end else begin
            if (i_cmd.tick_upd && rd_zero) begin
                r_pend[r_ptr] <= 1'b1;
            end
            if (i_cmd.add_wr) begin
                r_valid[r_ptr] <= 1'b1;
                r_pend[r_ptr]  <= 1'b0;
            end
            if (i_cmd.take) begin
                r_pend[r_ptr] <= 1'b0;
                // one-shot task leaves the table once run
                if (r_rd.period == '0) begin
                    r_valid[r_ptr] <= 1'b0;
                end
            end
        end
    end

    // Held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.cap) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.add_wr || i_cmd.take) begin
            r_hold_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_hold_idx   <= r_ptr;
            r_hold_ident <= r_ident;
        end else if (i_cmd.take) begin
            r_hold_idx   <= r_ptr;
            r_hold_ident <= r_rd.ident;
        end
    end

    // Output register: held result goes out when the next one replaces it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.take && r_hold_valid) || i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_hold_valid) begin
            r_out_kind  <= tts_pkg::RES_RUN;
            r_out_slot  <= tts_pkg::SLOT_W'(r_hold_idx);
            r_out_ident <= r_hold_ident;
            r_out_last  <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_last <= 1'b1;
            if (r_hold_valid) begin
                r_out_kind  <= (r_kind == tts_pkg::KIND_ADD) ? tts_pkg::RES_ADDED
                                                             : tts_pkg::RES_RUN;
                r_out_slot  <= tts_pkg::SLOT_W'(r_hold_idx);
                r_out_ident <= r_hold_ident;
            end else begin
                r_out_kind  <= (r_kind == tts_pkg::KIND_ADD) ? tts_pkg::RES_FULL
                                                             : tts_pkg::RES_IDLE;
                r_out_slot  <= '0;
                r_out_ident <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_slot  = r_out_slot;
    assign o_out_ident = r_out_ident;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/core/tts_ctrl.sv =====
// Controller: walks the slot table one slot per read/evaluate pair.
module tts_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tts_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_in_ready,
    input  tts_pkg::t_dp_sts            i_sts,
    output tts_pkg::t_dp_cmd            o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   accept;
    logic   done;

    assign accept     = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    // Next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        done    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap = 1'b1;
                    // unused kind: no work, no result
                    if (i_kind inside {tts_pkg::KIND_TICK, tts_pkg::KIND_ADD,
                                       tts_pkg::KIND_DISPATCH}) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EX;
            end
            S_EX: begin
                case (i_sts.kind)
                    tts_pkg::KIND_TICK: begin
                        o_cmd.tick_upd = i_sts.slot_valid;
                    end
                    tts_pkg::KIND_ADD: begin
                        if (!i_sts.slot_valid) begin
                            o_cmd.add_wr = 1'b1;
                            done         = 1'b0;
                            n_state      = S_FIN;
                        end
                    end
                    tts_pkg::KIND_DISPATCH: begin
                        if (i_sts.slot_valid && i_sts.slot_pend) begin
                            // a held result must leave before a new one is held
                            if (!i_sts.hold_valid || i_sts.out_free) begin
                                o_cmd.take = 1'b1;
                            end else begin
                                done = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (done && (n_state == S_EX)) begin
                    if (i_sts.ptr_last) begin
                        n_state = (i_sts.kind == tts_pkg::KIND_TICK) ? S_IDLE : S_FIN;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ===== rtl/core/tick_task_scheduler_top.sv =====
// Tick task scheduler: top level joining controller and slot datapath.
// Tick: reads and evaluates every slot in turn, then returns to idle.
// Add: scans to the first free slot and reports it, or reports full after the whole table.
// Dispatch: scans every slot, stalling while the output is busy; a result per ready slot as scanned.
// Rate set by the scan: one slot memory read and one evaluate step per slot.
// Synchronous active-low reset empties the table; slot contents are rewritten on add.
`include "tick_task_scheduler_top_defines.svh"

module tick_task_scheduler_top #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] task_ident, [23:8] start_delay, [39:24] repeat_period
    input  logic [tts_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] kind
    input  logic [tts_pkg::KIND_W-1:0]       i_s_axis_tuser,
    // result word
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [5:0] slot_index, [13:6] run_ident, [15:14] zero
    output logic [tts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [1:0] result_kind
    output logic [tts_pkg::RES_W-1:0]        o_m_axis_tuser,
    // last_of_run
    output logic                             o_m_axis_tlast
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    tts_pkg::t_dp_cmd cmd;
    tts_pkg::t_dp_sts sts;

    logic [tts_pkg::SLOT_W-1:0] out_slot;
    logic [tts_pkg::ID_W-1:0]   out_ident;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tts_dp #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_s_axis_tuser),
        .i_ident     (i_s_axis_tdata[7:0]),
        .i_sdelay    (i_s_axis_tdata[23:8]),
        .i_period    (i_s_axis_tdata[39:24]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_slot  (out_slot),
        .o_out_ident (out_ident),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_ident, out_slot};

    // Output register is only loaded when it is free
    `TTS_ASSERT(a_out_load_free, !(cmd.take && sts.hold_valid) || sts.out_free, "output busy")
    // Closing result of a word appears with its last flag
    `TTS_ASSERT_NEXT(a_fin_last, cmd.fin, o_m_axis_tvalid && o_m_axis_tlast, "closing word lost")
    // Add only ever fills an empty slot
    `TTS_ASSERT(a_add_free_slot, !cmd.add_wr || !sts.slot_valid, "add over occupied slot")

endmodule

// ===== sim/tts_result_checker.sv =====
// Result checker for the tick task scheduler: predicts and checks every result word.
`timescale 1ns / 1ps

module tts_result_checker #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word channel, observed only
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [tts_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [tts_pkg::KIND_W-1:0]     i_s_tuser,
    // result word channel, observed only
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [tts_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [tts_pkg::RES_W-1:0]      i_m_tuser,
    input  logic                           i_m_tlast,
    output int                             o_fail_count,
    output int                             o_words_due
);

    localparam int SLOT_W     = tts_pkg::SLOT_W;
    localparam int ID_W       = tts_pkg::ID_W;
    localparam int TIME_W     = tts_pkg::TIME_W;
    localparam int RES_W      = tts_pkg::RES_W;
    localparam int KIND_W     = tts_pkg::KIND_W;
    localparam int IN_DATA_W  = tts_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = tts_pkg::OUT_DATA_W;

    typedef struct packed {
        logic [RES_W-1:0]  kind;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   ident;
        logic              last;
    } t_sched_result;

    // Own copy of the task table
    logic              slot_used   [MAX_TASKS];
    logic [ID_W-1:0]   task_id     [MAX_TASKS];
    logic [TIME_W-1:0] ticks_left  [MAX_TASKS];
    logic [TIME_W-1:0] period_ticks[MAX_TASKS];
    logic              run_due     [MAX_TASKS];

    t_sched_result due_results[$];
    int            fails = 0;

    function automatic void push_result(logic [RES_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                        logic [ID_W-1:0] ident, logic last);
        due_results.push_back('{kind: kind, slot: slot, ident: ident, last: last});
    endfunction

    // Advance the table by one accepted word and queue the results it causes
    function automatic void schedule_word(logic [KIND_W-1:0] kind,
                                          logic [IN_DATA_W-1:0] data);
        logic [ID_W-1:0]   ident;
        logic [TIME_W-1:0] sdelay;
        logic [TIME_W-1:0] period;
        int                free_slot;
        int                n_run;
        ident     = data[ID_W-1:0];
        sdelay    = data[ID_W+TIME_W-1:ID_W];
        period    = data[ID_W+2*TIME_W-1:ID_W+TIME_W];
        free_slot = -1;
        n_run     = 0;
        case (kind)
            tts_pkg::KIND_TICK: begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (slot_used[i]) begin
                        if (ticks_left[i] == '0) begin
                            run_due[i] = 1'b1;
                            if (period_ticks[i] != '0)
                                ticks_left[i] = period_ticks[i];
                        end else begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
            end
            tts_pkg::KIND_ADD: begin
                for (int i = 0; i < MAX_TASKS; i++)
                    if (!slot_used[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0) begin
                    push_result(tts_pkg::RES_FULL, '0, '0, 1'b1);
                end else begin
                    slot_used[free_slot]    = 1'b1;
                    task_id[free_slot]      = ident;
                    ticks_left[free_slot]   = sdelay;
                    period_ticks[free_slot] = period;
                    run_due[free_slot]      = 1'b0;
                    push_result(tts_pkg::RES_ADDED, SLOT_W'(free_slot), ident, 1'b1);
                end
            end
            tts_pkg::KIND_DISPATCH: begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (slot_used[i] && run_due[i]) begin
                        push_result(tts_pkg::RES_RUN, SLOT_W'(i), task_id[i], 1'b0);
                        n_run++;
                        run_due[i] = 1'b0;
                        // one-shot task leaves the table once it has run
                        if (period_ticks[i] == '0) begin
                            slot_used[i]    = 1'b0;
                            task_id[i]      = '0;
                            ticks_left[i]   = '0;
                            period_ticks[i] = '0;
                        end
                    end
                end
                if (n_run == 0)
                    push_result(tts_pkg::RES_IDLE, '0, '0, 1'b1);
                else
                    due_results[due_results.size()-1].last = 1'b1;
            end
            default: ;  // spare kind: ignored
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Sample both channels at the clock edge; results before the new word
    always @(posedge i_clk) begin
        t_sched_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                slot_used[i]    = 1'b0;
                task_id[i]      = '0;
                ticks_left[i]   = '0;
                period_ticks[i] = '0;
                run_due[i]      = 1'b0;
            end
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result word with nothing expected: kind %0d data %h last %b",
                           i_m_tuser, i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", 16'(want.kind), 16'(i_m_tuser));
                    check_field("slot_index", 16'(want.slot), 16'(i_m_tdata[SLOT_W-1:0]));
                    check_field("run_ident", 16'(want.ident),
                                16'(i_m_tdata[SLOT_W+ID_W-1:SLOT_W]));
                    check_field("last_of_run", 16'(want.last), 16'(i_m_tlast));
                end
                check_field("pad", 16'd0, 16'(i_m_tdata[OUT_DATA_W-1:SLOT_W+ID_W]));
            end
            if (i_s_tvalid && i_s_tready)
                schedule_word(i_s_tuser, i_s_tdata);
        end
        o_words_due  <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the tick task scheduler testbench: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int KIND_W     = tts_pkg::KIND_W;
    localparam int ID_W       = tts_pkg::ID_W;
    localparam int TIME_W     = tts_pkg::TIME_W;
    localparam int RES_W      = tts_pkg::RES_W;
    localparam int IN_DATA_W  = tts_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = tts_pkg::OUT_DATA_W;

    localparam int MAX_TASKS      = tts_pkg::MAX_TASKS_DEF;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_WORDS   = 350;
    localparam int PHASE_LEN      = 125;
    localparam int LONG_LIVED_MAX = 3;
    localparam int DRAIN_CYCLES   = 4 * MAX_TASKS + 8;
    localparam int CYCLE_LIMIT    = 400000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = tts_pkg::KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [RES_W-1:0]      m_tuser;
    logic                  m_tlast;

    int fail_count;
    int words_due;
    int cycles        = 0;
    int words_sent    = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 45;
    int long_lived    = 0;

    tick_task_scheduler_top #(.MAX_TASKS(MAX_TASKS)) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    tts_result_checker #(.MAX_TASKS(MAX_TASKS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word, with a random gap first, and wait for it to be taken
    task automatic put_word(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ident,
                            input logic [TIME_W-1:0] sdelay,
                            input logic [TIME_W-1:0] period);
        // pacing: receiver idles more first, then sender, then neither
        if (words_sent == PHASE_LEN) begin
            send_idle_pct = 45;
            recv_idle_pct <= 25;
        end else if (words_sent == 2 * PHASE_LEN) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {period, sdelay, ident};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Tick, dispatch or spare word; the payload is don't-care, so randomise it
    task automatic put_control(input logic [KIND_W-1:0] kind);
        put_word(kind, ID_W'($urandom_range(0, 255)), TIME_W'($urandom_range(0, 65535)),
                 TIME_W'($urandom_range(0, 65535)));
    endtask

    // Mostly short one-shot tasks so slots keep turning over; a few stay for good
    task automatic put_random_add();
        logic [TIME_W-1:0] sdelay;
        logic [TIME_W-1:0] period;
        if (long_lived < LONG_LIVED_MAX && $urandom_range(0, 99) < 15) begin
            long_lived++;
            if ($urandom_range(0, 1)) begin
                sdelay = TIME_W'($urandom_range(0, 4));
                period = TIME_W'($urandom_range(1, 6));
            end else begin
                sdelay = TIME_W'($urandom_range(0, 65535));
                period = TIME_W'($urandom_range(0, 65535));
            end
        end else begin
            sdelay = TIME_W'($urandom_range(0, 4));
            period = '0;
        end
        put_word(tts_pkg::KIND_ADD, ID_W'($urandom_range(0, 255)), sdelay, period);
    endtask

    initial begin
        int pick;
        int counted;
        counted = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing ready, tick does nothing, spare kind ignored
        put_control(tts_pkg::KIND_DISPATCH);
        put_control(tts_pkg::KIND_TICK);
        put_control(KIND_SPARE);
        // fill every slot: ident zero one-shot, all-ones extremes, periodic and one-shots
        put_word(tts_pkg::KIND_ADD, 8'h00, 16'd0, 16'd0);
        put_word(tts_pkg::KIND_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
        put_word(tts_pkg::KIND_ADD, 8'hA5, 16'd1, 16'd1);
        put_word(tts_pkg::KIND_ADD, 8'h5A, 16'd2, 16'd0);
        for (int k = 4; k < MAX_TASKS; k++)
            put_word(tts_pkg::KIND_ADD, ID_W'(8'h10 + k), TIME_W'(k % 2), 16'd0);
        // table full
        put_word(tts_pkg::KIND_ADD, 8'h77, 16'd3, 16'd3);
        // several ready at once, one-shots freed, freed slot reused
        put_control(tts_pkg::KIND_TICK);
        put_control(tts_pkg::KIND_DISPATCH);
        put_word(tts_pkg::KIND_ADD, 8'h3C, 16'd0, 16'd0);
        put_control(tts_pkg::KIND_TICK);
        put_control(tts_pkg::KIND_TICK);
        put_control(tts_pkg::KIND_DISPATCH);
        put_control(tts_pkg::KIND_DISPATCH);

        // random traffic
        while (counted < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                put_control(KIND_SPARE);
            end else begin
                counted++;
                if (pick < 45)
                    put_control(tts_pkg::KIND_TICK);
                else if (pick < 68)
                    put_random_add();
                else
                    put_control(tts_pkg::KIND_DISPATCH);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // drain outstanding results, then let any scan finish
        while (words_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_dp.sv
rtl/core/tts_ctrl.sv
rtl/core/tick_task_scheduler_top.sv
sim/tts_result_checker.sv
sim/testbench.sv
